/* hdl/magic_multiplier_checker_core_assert.svh */
// Assertion macros shared by the checker RTL.
`ifndef MAGIC_MULTIPLIER_CHECKER_CORE_ASSERT_SVH
`define MAGIC_MULTIPLIER_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication under asynchronous active-low reset.
`define MMC_ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under asynchronous active-low reset.
`define MMC_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mmc_pkg.sv */
// Shared types, constants and board geometry functions of the multiplier checker.
`default_nettype none
package mmc_pkg;

	localparam int SQ_W       = 6;
	localparam int BITS_W     = 5;
	localparam int CAND_W     = 64;
	localparam int EPOCH_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SQUARE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KIND   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BITS   = 2'd2;

	localparam logic [3:0] INDEX_BITS_RESET = 4'd12;

	localparam int STEP_R [8] = '{0, 0, 1, -1, 1, 1, -1, -1};
	localparam int STEP_F [8] = '{1, -1, 0, 0, 1, -1, 1, -1};

	typedef struct packed {
		logic [SQ_W-1:0] square;
		logic            kind;
		logic [3:0]      index_bits;
	} cfg_t;

	function automatic logic on_board(input int r, input int f);
		return (r >= 0) && (r <= 7) && (f >= 0) && (f <= 7);
	endfunction

	// Mask mode: relevant squares without the edge square of each ray.
	// Otherwise: attack set, each ray ending on its first blocker.
	function automatic logic [63:0] walk_rays(input logic [SQ_W-1:0] sq, input logic kind,
			input logic [63:0] blk, input logic mask_mode);
		logic [63:0] set;
		int rank;
		int file;
		int base;
		int dr;
		int df;
		int r;
		int f;
		logic stop;
		set  = '0;
		rank = int'(sq[5:3]);
		file = int'(sq[2:0]);
		base = kind ? 4 : 0;
		for (int d = 0; d < 4; d++) begin
			dr   = STEP_R[base + d];
			df   = STEP_F[base + d];
			stop = 1'b0;
			for (int s = 1; s < 8; s++) begin
				r = rank + dr * s;
				f = file + df * s;
				if (!stop) begin
					if (!on_board(r, f)) begin
						stop = 1'b1;
					end else if (mask_mode && !on_board(r + dr, f + df)) begin
						stop = 1'b1;
					end else begin
						set[6'(r * 8 + f)] = 1'b1;
						if (!mask_mode && blk[6'(r * 8 + f)]) begin
							stop = 1'b1;
						end
					end
				end
			end
		end
		return set;
	endfunction

endpackage
`default_nettype wire

/* hdl/magic_multiplier_checker_core.sv */
// Top level of the magic multiplier checker: configuration, intake queue, search engine.
`default_nettype none
// Tests one 64-bit candidate multiplier per item for the configured square, piece kind
// and index width, and returns one item with the verdict and the candidate echoed. A
// candidate is taken, its relevant-occupancy mask is scanned, and then every occupancy
// goes through the hash pipeline, one occupancy per cycle (deposit, attack walk and three
// 32x32 partial products, hash, table read and check); the pipeline drains and the
// result is posted. The collision table is one memory port pair, which sets the
// one-per-cycle walk. Table entries carry an 8-bit epoch instead of a used flag; on the
// first candidate after reset and on every 255th candidate after that, the engine
// sweeps all 2^MAX_INDEX_BITS table entries before the walk. Up to two candidates queue
// while the engine is busy, and a finished result waits in its own register so the next
// candidate can start. Index widths above MAX_INDEX_BITS saturate. Write configuration
// only while idle.
module magic_multiplier_checker_core #(
	parameter int MAX_INDEX_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mmc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [63:0]                   candidate,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               accepted,
	output logic [63:0]                        accepted_candidate
);

	mmc_pkg::cfg_t              cfg_q;
	logic                       q_valid;
	logic                       q_stall;
	logic [mmc_pkg::CAND_W-1:0] q_data;

	// Configuration registers; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.square     <= '0;
			cfg_q.kind       <= 1'b0;
			cfg_q.index_bits <= mmc_pkg::INDEX_BITS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmc_pkg::REG_SQUARE: cfg_q.square     <= cfg_data[5:0];
				mmc_pkg::REG_KIND:   cfg_q.kind       <= cfg_data[0];
				mmc_pkg::REG_BITS:   cfg_q.index_bits <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Hold incoming items while the engine works.
	mmc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_stall (in_stall),
		.push_data  (candidate),
		.pop_valid  (q_valid),
		.pop_stall  (q_stall),
		.pop_data   (q_data)
	);

	// Walk every occupancy and check the hash table.
	mmc_engine #(
		.MAX_INDEX_BITS (MAX_INDEX_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cand_valid   (q_valid),
		.cand_stall   (q_stall),
		.cand_data    (q_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_accepted (accepted),
		.out_cand     (accepted_candidate)
	);

endmodule
`default_nettype wire

/* hdl/mmc_fifo.sv */
// Two-entry candidate queue between the intake and the search engine.
`default_nettype none
module mmc_fifo (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push_valid,
	output logic                           push_stall,
	input  wire logic [mmc_pkg::CAND_W-1:0] push_data,
	output logic                           pop_valid,
	input  wire logic                      pop_stall,
	output logic [mmc_pkg::CAND_W-1:0]     pop_data
);

	logic [mmc_pkg::CAND_W-1:0]     data_q [mmc_pkg::FIFO_DEPTH];
	logic [mmc_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [mmc_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [mmc_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic                           push;
	logic                           pop;

	assign push_stall = (cnt_q == mmc_pkg::FIFO_CNT_W'(mmc_pkg::FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = data_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

/* hdl/mmc_engine.sv */
// Search engine: walks all occupancies of one candidate through a hashing pipeline.
`default_nettype none
`include "magic_multiplier_checker_core_assert.svh"
module mmc_engine #(
	parameter int MAX_INDEX_BITS = 12
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire mmc_pkg::cfg_t             cfg,
	input  wire logic                      cand_valid,
	output logic                           cand_stall,
	input  wire logic [mmc_pkg::CAND_W-1:0] cand_data,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           out_accepted,
	output logic [mmc_pkg::CAND_W-1:0]     out_cand
);

	localparam int DEPTH  = 1 << MAX_INDEX_BITS;
	localparam int IDX_W  = MAX_INDEX_BITS;
	localparam int CNT_W  = MAX_INDEX_BITS + 1;
	localparam int PCNT_W = $clog2(MAX_INDEX_BITS + 1);
	localparam int PI_W   = $clog2(MAX_INDEX_BITS);
	localparam int MEM_W  = mmc_pkg::EPOCH_W + 64;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_CLEAR = 6'b000100,
		ST_WALK  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_DONE  = 6'b100000
	} eng_state_t;

	eng_state_t                       st_q;
	logic [mmc_pkg::CAND_W-1:0]       cand_q;
	logic [mmc_pkg::SQ_W-1:0]         sq_q;
	logic                             kind_q;
	logic [mmc_pkg::BITS_W-1:0]       bits_q;
	logic [5:0]                       pos_q [MAX_INDEX_BITS];
	logic [PCNT_W-1:0]                pcnt_q;
	logic [5:0]                       scan_q;
	logic [IDX_W-1:0]                 clr_q;
	logic [CNT_W-1:0]                 idx_q;
	logic [mmc_pkg::EPOCH_W-1:0]      epoch_q;
	logic                             ok_q;
	logic                             out_valid_q;
	logic                             out_acc_q;
	logic [mmc_pkg::CAND_W-1:0]       out_cand_q;

	logic                             v_s1, v_s2, v_s3, v_s4;
	logic [63:0]                      occ_s1;
	logic [63:0]                      att_s2, att_s3, att_s4;
	logic [63:0]                      pll_s2;
	logic [31:0]                      plh_s2, phl_s2;
	logic [IDX_W-1:0]                 slot_s3, slot_s4;
	logic [MEM_W-1:0]                 rd_q;
	logic                             fwd_v_q;
	logic [IDX_W-1:0]                 fwd_slot_q;
	logic [MEM_W-1:0]                 fwd_data_q;
	logic [MEM_W-1:0]                 mem [DEPTH];

	logic [63:0]                      mask;
	logic [63:0]                      occ_d;
	logic [CNT_W-1:0]                 entries;
	logic [63:0]                      prod;
	logic [IDX_W-1:0]                 slot_d;
	logic [MEM_W-1:0]                 cur;
	logic                             used;
	logic                             wr_walk;
	logic                             wr_clr;
	logic                             conflict;
	logic                             done_fire;
	logic                             start;
	logic                             pipe_busy;
	logic [mmc_pkg::BITS_W-1:0]       bits_eff;

	assign cand_stall = (st_q != ST_IDLE);
	assign start      = cand_valid && (st_q == ST_IDLE);
	assign entries    = CNT_W'(1) << bits_q;
	assign mask       = mmc_pkg::walk_rays(sq_q, kind_q, 64'd0, 1'b1);
	assign pipe_busy  = v_s1 || v_s2 || v_s3 || v_s4;
	assign done_fire  = (st_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign bits_eff   = ({1'b0, cfg.index_bits} > mmc_pkg::BITS_W'(MAX_INDEX_BITS)) ?
		mmc_pkg::BITS_W'(MAX_INDEX_BITS) : {1'b0, cfg.index_bits};

	assign out_valid    = out_valid_q;
	assign out_accepted = out_acc_q;
	assign out_cand     = out_cand_q;

	// Scatter the index bits onto the recorded mask positions.
	always_comb begin
		occ_d = '0;
		for (int j = 0; j < MAX_INDEX_BITS; j++) begin
			if ((j < int'(bits_q)) && (j < int'(pcnt_q)) && idx_q[j]) begin
				occ_d[pos_q[j]] = 1'b1;
			end
		end
	end

	assign prod   = pll_s2 + {plh_s2 + phl_s2, 32'h0};
	assign slot_d = IDX_W'(prod >> (7'd64 - 7'(bits_q)));

	assign cur      = (fwd_v_q && (fwd_slot_q == slot_s4)) ? fwd_data_q : rd_q;
	assign used     = (cur[MEM_W-1:64] == epoch_q);
	assign wr_walk  = v_s4 && !used;
	assign conflict = v_s4 && used && (cur[63:0] != att_s4);
	assign wr_clr   = (st_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pcnt_q      <= '0;
			scan_q      <= '0;
			clr_q       <= '0;
			idx_q       <= '0;
			epoch_q     <= '0;
			ok_q        <= 1'b1;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			fwd_v_q     <= 1'b0;
		end else begin
			v_s1    <= (st_q == ST_WALK);
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			fwd_v_q <= wr_walk;
			if (conflict) begin
				ok_q <= 1'b0;
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						pcnt_q <= '0;
						scan_q <= '0;
						ok_q   <= 1'b1;
						st_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (mask[scan_q] && (int'(pcnt_q) < MAX_INDEX_BITS)) begin
						pcnt_q <= pcnt_q + 1'b1;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == 6'd63) begin
						idx_q <= '0;
						clr_q <= '0;
						st_q  <= (epoch_q == '0) ? ST_CLEAR : ST_WALK;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						epoch_q <= mmc_pkg::EPOCH_W'(1);
						st_q    <= ST_WALK;
					end
				end
				ST_WALK: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == entries - 1'b1) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						epoch_q <= epoch_q + 1'b1;
						st_q    <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (start) begin
			cand_q <= cand_data;
			sq_q   <= cfg.square;
			kind_q <= cfg.kind;
			bits_q <= bits_eff;
		end
		if ((st_q == ST_SCAN) && mask[scan_q] && (int'(pcnt_q) < MAX_INDEX_BITS)) begin
			pos_q[pcnt_q[PI_W-1:0]] <= scan_q;
		end
		if (done_fire) begin
			out_acc_q  <= ok_q;
			out_cand_q <= cand_q;
		end
		occ_s1     <= occ_d;
		att_s2     <= mmc_pkg::walk_rays(sq_q, kind_q, occ_s1, 1'b0);
		pll_s2     <= {32'h0, occ_s1[31:0]} * {32'h0, cand_q[31:0]};
		plh_s2     <= occ_s1[31:0] * cand_q[63:32];
		phl_s2     <= occ_s1[63:32] * cand_q[31:0];
		att_s3     <= att_s2;
		slot_s3    <= slot_d;
		att_s4     <= att_s3;
		slot_s4    <= slot_s3;
		fwd_slot_q <= slot_s4;
		fwd_data_q <= {epoch_q, att_s4};
	end

	// Collision table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_clr) begin
			mem[clr_q] <= '0;
		end else if (wr_walk) begin
			mem[slot_s4] <= {epoch_q, att_s4};
		end
		if (v_s3) begin
			rd_q <= mem[slot_s3];
		end
	end

	`MMC_ASSERT_IMPL(a_walk_in_range, clk, arst_n, st_q == ST_WALK, idx_q < entries, "index past table")
	`MMC_ASSERT_IMPL(a_epoch_live, clk, arst_n, v_s4, epoch_q != '0, "walk with stale epoch")
	`MMC_ASSERT_IMPL(a_clear_alone, clk, arst_n, wr_clr, !pipe_busy, "clear overlaps walk")

endmodule
`default_nettype wire

/* tb/tb_magic_multiplier_checker_core.sv */
// Testbench for the magic multiplier checker: directed and random candidates, scoreboarded.
`timescale 1ns / 100ps
`default_nettype none

// Tracks the configuration, predicts each verdict and compares it with the block's output.
class verdict_scoreboard;
	typedef struct {
		logic        ok;
		logic [63:0] cand;
	} verdict_t;

	logic [5:0] sq;
	logic       kind;
	logic [3:0] bits;
	verdict_t   awaited[$];
	int         mismatches;
	logic [63:0] slot_att[4096];
	bit          slot_taken[4096];

	function new();
		sq         = '0;
		kind       = 1'b0;
		bits       = mmc_pkg::INDEX_BITS_RESET;
		mismatches = 0;
	endfunction

	// Walk the four rays of the piece: the relevant mask (edge squares dropped) or the
	// attack set (each ray ends on its first blocker).
	function logic [63:0] rays(logic [63:0] blk, bit mask_only);
		int dr [8] = '{0, 0, 1, -1, 1, 1, -1, -1};
		int df [8] = '{1, -1, 0, 0, 1, -1, 1, -1};
		logic [63:0] acc;
		int r;
		int f;
		acc = '0;
		for (int d = 0; d < 4; d++) begin
			r = int'(sq[5:3]) + dr[d + (kind ? 4 : 0)];
			f = int'(sq[2:0]) + df[d + (kind ? 4 : 0)];
			while (r >= 0 && r <= 7 && f >= 0 && f <= 7) begin
				if (mask_only) begin
					if (r + dr[d + (kind ? 4 : 0)] < 0 || r + dr[d + (kind ? 4 : 0)] > 7 ||
							f + df[d + (kind ? 4 : 0)] < 0 || f + df[d + (kind ? 4 : 0)] > 7)
						break;
				end
				acc[r * 8 + f] = 1'b1;
				if (!mask_only && blk[r * 8 + f])
					break;
				r += dr[d + (kind ? 4 : 0)];
				f += df[d + (kind ? 4 : 0)];
			end
		end
		return acc;
	endfunction

	// Note an accepted candidate: run the whole collision search and queue the verdict.
	function void note_candidate(logic [63:0] cand);
		int          nb;
		int          slot;
		int          k;
		logic [63:0] mask;
		logic [63:0] occ;
		logic [63:0] att;
		logic [63:0] prod;
		verdict_t    v;
		nb   = (bits > 12) ? 12 : int'(bits);
		mask = rays('0, 1'b1);
		v.ok = 1'b1;
		v.cand = cand;
		foreach (slot_taken[j])
			slot_taken[j] = 1'b0;
		for (int idx = 0; idx < (1 << nb) && v.ok; idx++) begin
			occ = '0;
			k   = 0;
			for (int s = 0; s < 64; s++) begin
				if (mask[s]) begin
					if (k < nb && idx[k])
						occ[s] = 1'b1;
					k++;
				end
			end
			att  = rays(occ, 1'b0);
			prod = occ * cand;
			slot = (nb == 0) ? 0 : int'(prod >> (64 - nb));
			if (!slot_taken[slot]) begin
				slot_taken[slot] = 1'b1;
				slot_att[slot]   = att;
			end else if (slot_att[slot] != att) begin
				v.ok = 1'b0;
			end
		end
		awaited.push_back(v);
	endfunction

	// Check one result item against the oldest verdict.
	function void check_result(logic ok, logic [63:0] cand);
		verdict_t v;
		if (awaited.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: accepted=%0b candidate=%h", ok, cand);
			return;
		end
		v = awaited.pop_front();
		if (ok !== v.ok || cand !== v.cand) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected accepted=%0b candidate=%h, got %0b %h",
					v.ok, v.cand, ok, cand);
		end
	endfunction
endclass

module tb_magic_multiplier_checker_core;

	localparam longint CYCLE_LIMIT = 3000000;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [mmc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mmc_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic [63:0]                    candidate;
	logic                           out_valid;
	logic                           out_stall;
	logic                           accepted;
	logic [63:0]                    accepted_candidate;

	verdict_scoreboard sb;
	longint            cycles;
	int                sent;

	magic_multiplier_checker_core i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.candidate          (candidate),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.accepted           (accepted),
		.accepted_candidate (accepted_candidate)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Idle pressure by progress: sender idles 34% and receiver 50%, then the other way
	// round, then neither idles.
	function automatic int send_gap_pct();
		return (sent < 47) ? 34 : (sent < 94) ? 50 : 0;
	endfunction

	function automatic int recv_stall_pct();
		return (sent < 47) ? 50 : (sent < 94) ? 34 : 0;
	endfunction

	// Receiver: take results at each edge and draw the next stall.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_valid && !out_stall)
					sb.check_result(accepted, accepted_candidate);
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct());
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL magic_multiplier_checker_core");
				$finish;
			end
		end
	end

	// Write one register; the block must be idle. The caller drops the write enable.
	task automatic write_reg(logic [mmc_pkg::CFG_IDX_W-1:0] idx,
			logic [mmc_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			mmc_pkg::REG_SQUARE: sb.sq   = val[5:0];
			mmc_pkg::REG_KIND:   sb.kind = val[0];
			mmc_pkg::REG_BITS:   sb.bits = val[3:0];
			default: ;
		endcase
	endtask

	// Drain outstanding results, let the engine settle, then load a new setting.
	task automatic set_mode(logic [5:0] s, logic k, logic [3:0] b);
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		write_reg(mmc_pkg::REG_SQUARE, mmc_pkg::CFG_DATA_W'(s));
		write_reg(mmc_pkg::REG_KIND, mmc_pkg::CFG_DATA_W'(k));
		write_reg(mmc_pkg::REG_BITS, mmc_pkg::CFG_DATA_W'(b));
		cfg_we <= 1'b0;
	endtask

	// Offer one candidate, with a random gap first; hold it until accepted.
	task automatic send_candidate(logic [63:0] c);
		int gap;
		gap = ($urandom_range(0, 99) < send_gap_pct()) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		candidate <= c;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_candidate(c);
		sent++;
	endtask

	function automatic logic [63:0] rand_cand();
		logic [63:0] c;
		c = {$urandom(), $urandom()};
		// sparse multipliers now and then
		if ($urandom_range(0, 3) == 0)
			c &= {$urandom(), $urandom()} & {$urandom(), $urandom()};
		return c;
	endfunction

	// Send a short batch, then drop valid.
	task automatic send_batch(int n);
		for (int i = 0; i < n; i++)
			send_candidate(rand_cand());
		in_valid <= 1'b0;
	endtask

	initial begin
		logic [3:0] b;
		sb        = new();
		sent      = 0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		candidate = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: rook on a corner, full index width; zero and all-ones multipliers.
		send_candidate('0);
		send_candidate('1);
		in_valid <= 1'b0;
		// Index width zero: single slot, always accepted.
		set_mode(6'd63, 1'b1, 4'd0);
		send_candidate('1);
		send_batch(2);
		// One index bit on a center square.
		set_mode(6'd27, 1'b0, 4'd1);
		send_candidate(64'h8000_0000_0000_0000);
		send_batch(4);
		// Width above the maximum saturates; also exceeds the bishop's mask bits.
		set_mode(6'd7, 1'b1, 4'd15);
		send_batch(2);
		set_mode(6'd56, 1'b0, 4'd13);
		send_candidate(64'h0000_0000_0000_0001);
		in_valid <= 1'b0;
		set_mode(6'd36, 1'b1, 4'd4);
		send_batch(5);

		// Random settings, mostly narrow widths so that verdicts are mixed and runs short.
		while (sent < 135) begin
			b = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			set_mode(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), b);
			send_batch((b > 8) ? 3 : 12);
		end

		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0)
			$display("PASS magic_multiplier_checker_core");
		else
			$display("FAIL magic_multiplier_checker_core");
		$finish;
	end
endmodule
`default_nettype wire
